[hw/rtl/hdc_pkg.sv]
// ----------------------------------------------------------------------------
// hdc_pkg: shared types and codes for the heading hold drive controller
// Beat payload structs, configuration struct, request and mode codes, and
// register map constants used by the controller and its checker.
// ----------------------------------------------------------------------------
package hdc_pkg;

  // Internal angle and distance widths. Ports stay at the fixed field widths.
  localparam int ANGLE_BITS = 16;
  localparam int DIST_BITS  = 16;

  // Request codes carried in the func field.
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_STRAIGHT = 2'd1;
  localparam logic [1:0] FUNC_TURN     = 2'd2;

  // Codes reported in run_mode.
  localparam logic [1:0] RUN_IDLE     = 2'd0;
  localparam logic [1:0] RUN_STRAIGHT = 2'd1;
  localparam logic [1:0] RUN_TURN     = 2'd2;

  // Register map: index is paddr[4:2].
  localparam int         CFG_ADDR_BITS = 5;
  localparam int         CFG_DATA_BITS = 32;
  localparam logic [2:0] REG_STEER_GAIN    = 3'd0;
  localparam logic [2:0] REG_STEER_LIMIT   = 3'd1;
  localparam logic [2:0] REG_DRIVE_SPEED   = 3'd2;
  localparam logic [2:0] REG_TURN_RATE     = 3'd3;
  localparam logic [2:0] REG_HEADING_TOL   = 3'd4;
  localparam logic [2:0] REG_STEP_DISTANCE = 3'd5;

  localparam logic [15:0] RST_STEER_GAIN    = 16'd12868;
  localparam logic [14:0] RST_STEER_LIMIT   = 15'd1229;
  localparam logic [14:0] RST_DRIVE_SPEED   = 15'd2048;
  localparam logic [14:0] RST_TURN_RATE     = 15'd2048;
  localparam logic [14:0] RST_HEADING_TOL   = 15'd522;
  localparam logic [9:0]  RST_STEP_DISTANCE = 10'd10;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] yaw;
    logic [15:0]        distance_goal;
    logic signed [15:0] turn_delta;
  } hdc_in_t;

  typedef struct packed {
    logic               move_valid;
    logic [14:0]        forward_cmd;
    logic signed [15:0] yaw_rate_cmd;
    logic               stop_issued;
    logic               done_res;
    logic signed [15:0] heading_error;
    logic [1:0]         run_mode;
    logic               rejected;
  } hdc_out_t;

  typedef struct packed {
    logic [15:0] steer_gain;
    logic [14:0] steer_limit;
    logic [14:0] drive_speed;
    logic [14:0] turn_rate;
    logic [14:0] heading_tol;
    logic [9:0]  step_distance;
  } hdc_cfg_t;

endpackage

[hw/rtl/hdc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// hdc_cfg_regs: configuration register file
// APB-style write and read access to the six controller settings.
// ----------------------------------------------------------------------------
module hdc_cfg_regs import hdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output hdc_cfg_t                 cfg
);

  hdc_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steer_gain    <= RST_STEER_GAIN;
      cfg_r.steer_limit   <= RST_STEER_LIMIT;
      cfg_r.drive_speed   <= RST_DRIVE_SPEED;
      cfg_r.turn_rate     <= RST_TURN_RATE;
      cfg_r.heading_tol   <= RST_HEADING_TOL;
      cfg_r.step_distance <= RST_STEP_DISTANCE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_STEER_GAIN:    cfg_r.steer_gain    <= pwdata[15:0];
        REG_STEER_LIMIT:   cfg_r.steer_limit   <= pwdata[14:0];
        REG_DRIVE_SPEED:   cfg_r.drive_speed   <= pwdata[14:0];
        REG_TURN_RATE:     cfg_r.turn_rate     <= pwdata[14:0];
        REG_HEADING_TOL:   cfg_r.heading_tol   <= pwdata[14:0];
        REG_STEP_DISTANCE: cfg_r.step_distance <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEER_GAIN:    prdata = CFG_DATA_BITS'(cfg_r.steer_gain);
      REG_STEER_LIMIT:   prdata = CFG_DATA_BITS'(cfg_r.steer_limit);
      REG_DRIVE_SPEED:   prdata = CFG_DATA_BITS'(cfg_r.drive_speed);
      REG_TURN_RATE:     prdata = CFG_DATA_BITS'(cfg_r.turn_rate);
      REG_HEADING_TOL:   prdata = CFG_DATA_BITS'(cfg_r.heading_tol);
      REG_STEP_DISTANCE: prdata = CFG_DATA_BITS'(cfg_r.step_distance);
      default:           prdata = '0;
    endcase
  end

endmodule

[hw/rtl/hdc_core.sv]
// ----------------------------------------------------------------------------
// hdc_core: controller state and single-pass step logic
// Holds the target heading, run mode and distance state, computes the result
// of one registered request and commits the state when the request fires.
// ----------------------------------------------------------------------------
module hdc_core import hdc_pkg::*; #(
  parameter int ANGLE_W = ANGLE_BITS,
  parameter int DIST_W  = DIST_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  hdc_in_t  item,
  input  hdc_cfg_t cfg,
  output hdc_out_t res
);

  // Width of the signed compare domain for rates and error magnitudes.
  localparam int RW = (ANGLE_W + 1 > 17) ? ANGLE_W + 1 : 17;
  localparam int PW = ANGLE_W + 17;

  typedef enum logic [1:0] {
    MODE_IDLE     = RUN_IDLE,
    MODE_STRAIGHT = RUN_STRAIGHT,
    MODE_TURN     = RUN_TURN
  } mode_t;

  logic                      latched_r, latched_nxt;
  logic signed [ANGLE_W-1:0] target_r, target_nxt;
  mode_t                     mode_r, mode_nxt;
  logic [DIST_W:0]           trav_r, trav_nxt;
  logic [DIST_W-1:0]         goal_r, goal_nxt;

  logic signed [ANGLE_W-1:0] yaw_ang;
  logic signed [ANGLE_W-1:0] delta_ang;
  logic signed [ANGLE_W-1:0] err;
  logic signed [PW-1:0]      prod;
  logic signed [RW-1:0]      steer_raw;
  logic signed [RW-1:0]      lim_w;
  logic signed [RW-1:0]      steer_rate;
  logic signed [RW-1:0]      err_w;
  logic [RW-1:0]             err_mag;
  logic [DIST_W+1:0]         trav_sum;
  logic [DIST_W:0]           trav_inc;

  assign yaw_ang   = ANGLE_W'(item.yaw);
  assign delta_ang = ANGLE_W'(item.turn_delta);
  assign err       = target_r - yaw_ang;

  // Proportional steering: floor((err * gain) / 2^16), then clamp.
  assign prod      = err * $signed({1'b0, cfg.steer_gain});
  assign steer_raw = RW'(prod >>> 16);
  assign lim_w     = $signed(RW'(cfg.steer_limit));
  always_comb begin
    if (steer_raw > lim_w) begin
      steer_rate = lim_w;
    end else if (steer_raw < -lim_w) begin
      steer_rate = -lim_w;
    end else begin
      steer_rate = steer_raw;
    end
  end

  assign err_w   = RW'(err);
  assign err_mag = (err_w < 0) ? RW'(-err_w) : RW'(err_w);

  // Distance covered, saturating at the full width of the counter.
  assign trav_sum = {1'b0, trav_r} + (DIST_W + 2)'(cfg.step_distance);
  assign trav_inc = trav_sum[DIST_W+1] ? '1 : trav_sum[DIST_W:0];

  always_comb begin
    latched_nxt = latched_r;
    target_nxt  = target_r;
    mode_nxt    = mode_r;
    trav_nxt    = trav_r;
    goal_nxt    = goal_r;
    res         = '0;
    case (item.func)
      FUNC_TICK: begin
        if (!latched_r) begin
          target_nxt  = yaw_ang;
          latched_nxt = 1'b1;
        end else begin
          res.heading_error = 16'(err);
          case (mode_r)
            MODE_STRAIGHT: begin
              if (trav_r >= {1'b0, goal_r}) begin
                res.stop_issued = 1'b1;
                res.done_res    = 1'b1;
                mode_nxt        = MODE_IDLE;
              end else begin
                res.move_valid   = 1'b1;
                res.forward_cmd  = cfg.drive_speed;
                res.yaw_rate_cmd = 16'(steer_rate);
                trav_nxt         = trav_inc;
              end
            end
            MODE_TURN: begin
              if (err_mag < RW'(cfg.heading_tol)) begin
                res.stop_issued = 1'b1;
                res.done_res    = 1'b1;
                mode_nxt        = MODE_IDLE;
              end else begin
                res.move_valid   = 1'b1;
                res.yaw_rate_cmd = (err > 0) ? $signed({1'b0, cfg.turn_rate})
                                             : -$signed({1'b0, cfg.turn_rate});
              end
            end
            default: ;
          endcase
        end
      end
      FUNC_STRAIGHT: begin
        if (!latched_r) begin
          res.rejected = 1'b1;
        end else begin
          mode_nxt = MODE_STRAIGHT;
          trav_nxt = '0;
          goal_nxt = DIST_W'(item.distance_goal);
        end
      end
      FUNC_TURN: begin
        if (!latched_r) begin
          res.rejected = 1'b1;
        end else begin
          target_nxt = target_r + delta_ang;
          mode_nxt   = MODE_TURN;
        end
      end
      default: ;
    endcase
    res.run_mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= 1'b0;
      target_r  <= '0;
      mode_r    <= MODE_IDLE;
      trav_r    <= '0;
      goal_r    <= '0;
    end else if (fire) begin
      latched_r <= latched_nxt;
      target_r  <= target_nxt;
      mode_r    <= mode_nxt;
      trav_r    <= trav_nxt;
      goal_r    <= goal_nxt;
    end
  end

endmodule

[hw/rtl/heading_hold_drive_controller_top.sv]
// ----------------------------------------------------------------------------
// heading_hold_drive_controller_top: heading hold drive controller
// Input register, single-pass controller step and result register, plus the
// APB-style configuration registers.
// ----------------------------------------------------------------------------
// The controller takes one beat per clock cycle while the result side is not
// stalled, and returns exactly one result beat for each. A beat is either a
// control tick carrying the measured yaw or a command that starts a straight
// run or a turn. The first tick latches the measured yaw as the target
// heading; commands before it come back with the rejected flag set. The rate
// of one beat per cycle is set by the controller state loop: the step logic
// reads the state, computes the result and writes the next state in the same
// cycle, so the next beat always sees the state the previous one left. The
// accepted beat waits in the input register while the step logic works on
// it, and the result register loads when the beat fires and presents the
// result beat. A stall on the result side holds the result register, and the
// input register still fills, so one more beat is taken before in_stall
// rises. Settings are written through the APB-style port at byte address 4*i
// for register i and must only change while no beat is in flight.
module heading_hold_drive_controller_top import hdc_pkg::*; #(
  parameter int ANGLE_W = ANGLE_BITS,
  parameter int DIST_W  = DIST_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  hdc_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output hdc_out_t                 out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  hdc_cfg_t cfg;

  // Input register holding the beat about to be processed.
  logic     in_valid_r;
  hdc_in_t  in_data_r;

  // Result register.
  logic     out_valid_r;
  hdc_out_t out_data_r;

  logic     advance;
  logic     fire;
  hdc_out_t step_res;

  // The pipe moves whenever the result register is free or being emptied.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = advance && in_valid_r;
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  hdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hdc_core #(
    .ANGLE_W (ANGLE_W),
    .DIST_W  (DIST_W)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_data_r),
    .cfg   (cfg),
    .res   (step_res)
  );

endmodule

[hw/rtl/hdc_checker.sv]
// ----------------------------------------------------------------------------
// hdc_checker: port-level checks for the heading hold drive controller
// Watches the result channel and flags inconsistent result beats.
// ----------------------------------------------------------------------------
module hdc_checker import hdc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input hdc_out_t out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A rejected command never issues motion or ends a run.
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rejected |->
      !out_data.move_valid && !out_data.done_res && out_data.run_mode == RUN_IDLE)
    else $error("rejected beat carries motion or mode");

  // Finishing a run always stops the robot and leaves it idle.
  a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |->
      out_data.stop_issued && !out_data.move_valid && out_data.run_mode == RUN_IDLE)
    else $error("finished run without stop to idle");

  // Speed commands only appear with a move, and a move needs an active mode.
  a_cmd_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.move_valid |->
      out_data.forward_cmd == 15'd0 && out_data.yaw_rate_cmd == 16'sd0)
    else $error("speed command without move");

  a_move_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.move_valid |->
      out_data.run_mode == RUN_STRAIGHT || out_data.run_mode == RUN_TURN)
    else $error("move issued while idle");

endmodule

bind heading_hold_drive_controller_top hdc_checker u_hdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/heading_hold_drive_controller_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heading_hold_drive_controller_top_tb: self-checking bench for the controller
// Drives ticks and straight-run/turn commands through the valid/stall input
// channel, predicts every result beat with a cycle-free copy of the controller
// state and compares each field of each result beat in order. Four settings
// phases cover the register extremes, random settings and the reset values,
// with random idling on both channels and one long result-side hold-off.
// ----------------------------------------------------------------------------
module heading_hold_drive_controller_top_tb;
  import hdc_pkg::*;

  // The package has no name for the fourth func code; the block ignores it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int TRAV_MAX = (1 << (DIST_BITS + 1)) - 1;
  // The cycle limit leaves ample room for the worst legal run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 460;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  hdc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hdc_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  heading_hold_drive_controller_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Beats waiting to be offered, and the result beats predicted for the
  // beats already accepted, oldest first.
  hdc_in_t  queued_beats[$];
  hdc_out_t predicted_commands[$];

  int errors = 0;
  int accepted_beats = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Long result-side hold-off, counted here so the sender keeps pushing
  // until the block backs up and raises in_stall.
  int hold_left = 0;
  bit hold_spent = 1'b0;
  bit hold_kick = 1'b0;

  // Settings as the block should hold them, and the predicted controller state.
  hdc_cfg_t cfg_shadow = '{
    steer_gain: RST_STEER_GAIN, steer_limit: RST_STEER_LIMIT,
    drive_speed: RST_DRIVE_SPEED, turn_rate: RST_TURN_RATE,
    heading_tol: RST_HEADING_TOL, step_distance: RST_STEP_DISTANCE};
  bit          hold_latched = 1'b0;
  logic [15:0] hold_target = '0;
  logic [1:0]  run_state = RUN_IDLE;
  logic [16:0] covered_mm = '0;
  logic [15:0] run_goal = '0;

  // The stimulus generator tracks the target heading on its own so that it
  // can aim yaw values close to it; this only shapes traffic, never checks.
  bit          gen_latched = 1'b0;
  logic [15:0] gen_target = '0;

  // Advances the predicted controller by one accepted beat and returns the
  // result beat it must produce.
  task automatic advance_controller(input hdc_in_t beat, output hdc_out_t res);
    logic signed [15:0] err;
    longint rate;
    longint lim;
    int mag;
    int grown;
    res = '0;
    err = '0;
    rate = 0;
    case (beat.func)
      FUNC_TICK: begin
        if (!hold_latched) begin
          hold_target = beat.yaw;
          hold_latched = 1'b1;
        end else begin
          err = hold_target - beat.yaw;
          if (run_state == RUN_STRAIGHT) begin
            if (covered_mm >= {1'b0, run_goal}) begin
              res.stop_issued = 1'b1;
              res.done_res = 1'b1;
              run_state = RUN_IDLE;
            end else begin
              // Arithmetic shift of the signed product is a floor divide.
              lim = longint'(cfg_shadow.steer_limit);
              rate = (longint'(err) * longint'(cfg_shadow.steer_gain)) >>> 16;
              if (rate > lim) rate = lim;
              if (rate < -lim) rate = -lim;
              res.move_valid = 1'b1;
              res.forward_cmd = cfg_shadow.drive_speed;
              grown = int'(covered_mm) + int'(cfg_shadow.step_distance);
              if (grown > TRAV_MAX) grown = TRAV_MAX;
              covered_mm = grown[16:0];
            end
          end else if (run_state == RUN_TURN) begin
            mag = (err < 0) ? -int'(err) : int'(err);
            if (mag < int'(cfg_shadow.heading_tol)) begin
              res.stop_issued = 1'b1;
              res.done_res = 1'b1;
              run_state = RUN_IDLE;
            end else begin
              // Zero error with zero tolerance falls through to the negative rate.
              res.move_valid = 1'b1;
              rate = (err > 0) ? longint'(cfg_shadow.turn_rate)
                               : -longint'(cfg_shadow.turn_rate);
            end
          end
        end
      end
      FUNC_STRAIGHT: begin
        if (!hold_latched) begin
          res.rejected = 1'b1;
        end else begin
          run_state = RUN_STRAIGHT;
          covered_mm = '0;
          run_goal = beat.distance_goal;
        end
      end
      FUNC_TURN: begin
        if (!hold_latched) begin
          res.rejected = 1'b1;
        end else begin
          hold_target = hold_target + beat.turn_delta;
          run_state = RUN_TURN;
        end
      end
      default: ;
    endcase
    res.yaw_rate_cmd = rate[15:0];
    res.heading_error = err;
    res.run_mode = run_state;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
    end
  endtask

  task automatic compare_command(input hdc_out_t want, input hdc_out_t got);
    check_field("move_valid", 16'(want.move_valid), 16'(got.move_valid));
    check_field("forward_cmd", 16'(want.forward_cmd), 16'(got.forward_cmd));
    check_field("yaw_rate_cmd", want.yaw_rate_cmd, got.yaw_rate_cmd);
    check_field("stop_issued", 16'(want.stop_issued), 16'(got.stop_issued));
    check_field("done_res", 16'(want.done_res), 16'(got.done_res));
    check_field("heading_error", want.heading_error, got.heading_error);
    check_field("run_mode", 16'(want.run_mode), 16'(got.run_mode));
    check_field("rejected", 16'(want.rejected), 16'(got.rejected));
  endtask

  // Driver: a beat leaves the queue once the previous one has been taken,
  // unless the sender chooses to idle this cycle. The prediction is made at
  // the edge where the block accepts the beat.
  always @(posedge clk) begin
    hdc_out_t predicted;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_controller(in_data, predicted);
        predicted_commands.push_back(predicted);
        accepted_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= queued_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted result beat must match the oldest prediction.
  always @(posedge clk) begin
    hdc_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (predicted_commands.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected, expected nothing got %h",
                   $time, out_data);
        end else begin
          want = predicted_commands.pop_front();
          compare_command(want, out_data);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_spent <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_kick && !hold_spent) begin
      hold_left <= HOLD_CYCLES;
      hold_spent <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(0, 65535));
  endfunction

  // Queues one beat and keeps the generator's view of the target heading.
  task automatic queue_beat(input logic [1:0] code, input logic [15:0] yaw,
                            input logic [15:0] goal, input logic [15:0] delta);
    hdc_in_t beat;
    beat.func = code;
    beat.yaw = yaw;
    beat.distance_goal = goal;
    beat.turn_delta = delta;
    queued_beats.push_back(beat);
    if (code == FUNC_TICK && !gen_latched) begin
      gen_latched = 1'b1;
      gen_target = yaw;
    end else if (code == FUNC_TURN && gen_latched) begin
      gen_target = gen_target + delta;
    end
  endtask

  // A heading error to aim for: often right at the tolerance edge, else
  // uniform within the given spread.
  function automatic int pick_error(input int spread);
    int tol;
    tol = int'(cfg_shadow.heading_tol);
    if (tol > 0 && $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: return tol;
        1: return tol - 1;
        2: return -tol;
        default: return 1 - tol;
      endcase
    end
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic logic [15:0] yaw_for_error(input int err);
    return gen_target - 16'(err);
  endfunction

  // Random traffic: mostly whole missions (a command followed by ticks that
  // steer near the target), then free ticks and some noise.
  task automatic queue_mission_mix(input int count);
    int added;
    int kind;
    int n;
    int goal;
    int spread;
    logic [15:0] delta;
    logic [1:0] code;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        if ($urandom_range(0, 7) == 0) begin
          goal = $urandom_range(0, 65535);
        end else begin
          goal = int'(cfg_shadow.step_distance) * $urandom_range(0, 12)
               + $urandom_range(0, cfg_shadow.step_distance);
          if (goal > 65535) goal = 65535;
        end
        queue_beat(FUNC_STRAIGHT, rnd16(), 16'(goal), rnd16());
        n = $urandom_range(1, 16);
        spread = ($urandom_range(0, 3) == 0) ? 32768 : 2000;
        repeat (n) queue_beat(FUNC_TICK, yaw_for_error(pick_error(spread)), rnd16(), rnd16());
        added += n + 1;
      end else if (kind < 75) begin
        if ($urandom_range(0, 3) == 0) delta = rnd16();
        else delta = 16'(int'($urandom_range(0, 8000)) - 4000);
        queue_beat(FUNC_TURN, rnd16(), rnd16(), delta);
        n = $urandom_range(1, 12);
        repeat (n) begin
          spread = ($urandom_range(0, 3) == 0) ? 32768
                 : int'(cfg_shadow.heading_tol) + $urandom_range(0, 2);
          queue_beat(FUNC_TICK, yaw_for_error(pick_error(spread)), rnd16(), rnd16());
        end
        added += n + 1;
      end else if (kind < 88) begin
        n = $urandom_range(1, 6);
        repeat (n) queue_beat(FUNC_TICK, rnd16(), rnd16(), rnd16());
        added += n;
      end else begin
        code = 2'($urandom_range(0, 3));
        queue_beat(code, rnd16(), rnd16(), rnd16());
        if (code != FUNC_UNUSED) added++;
      end
    end
  endtask

  // Setup-then-access register write; the update lands at the access edge.
  task automatic write_setting(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_STEER_GAIN:    cfg_shadow.steer_gain = value[15:0];
      REG_STEER_LIMIT:   cfg_shadow.steer_limit = value[14:0];
      REG_DRIVE_SPEED:   cfg_shadow.drive_speed = value[14:0];
      REG_TURN_RATE:     cfg_shadow.turn_rate = value[14:0];
      REG_HEADING_TOL:   cfg_shadow.heading_tol = value[14:0];
      REG_STEP_DISTANCE: cfg_shadow.step_distance = value[9:0];
      default: ;
    endcase
  endtask

  task automatic write_all_settings(input logic [31:0] gain, input logic [31:0] limit,
                                    input logic [31:0] speed, input logic [31:0] rate,
                                    input logic [31:0] tol, input logic [31:0] step);
    write_setting(REG_STEER_GAIN, gain);
    write_setting(REG_STEER_LIMIT, limit);
    write_setting(REG_DRIVE_SPEED, speed);
    write_setting(REG_TURN_RATE, rate);
    write_setting(REG_HEADING_TOL, tol);
    write_setting(REG_STEP_DISTANCE, step);
  endtask

  // Waits until everything queued has been accepted and answered. Every beat
  // yields a result, so an empty prediction queue means the two-stage pipeline has drained.
  task automatic wait_drained();
    while (queued_beats.size() != 0 || in_valid || predicted_commands.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Sets the idling mix at a falling edge so the clocked processes see it
  // cleanly at the next rising edge.
  task automatic set_idling(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    int base;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: upper extremes with zero tolerance, directed beats first.
    write_all_settings(32'd65535, 32'd32767, 32'd32767, 32'd32767, 32'd0, 32'd1023);
    set_idling(11, 86);
    // Commands before the first tick are rejected; an unused code is ignored.
    queue_beat(FUNC_STRAIGHT, 16'h1234, 16'hFFFF, 16'h5A5A);
    queue_beat(FUNC_TURN, 16'hFFFF, 16'h0000, 16'h8000);
    queue_beat(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // The first tick latches the most negative heading; then an idle tick
    // with zero error and one with the smallest positive error.
    queue_beat(FUNC_TICK, 16'h8000, 16'hFFFF, 16'h7FFF);
    queue_beat(FUNC_TICK, 16'h8000, 16'h0000, 16'h0000);
    queue_beat(FUNC_TICK, 16'h7FFF, rnd16(), rnd16());
    // A zero-length run stops on its first tick.
    queue_beat(FUNC_STRAIGHT, rnd16(), 16'h0000, rnd16());
    queue_beat(FUNC_TICK, 16'h0000, rnd16(), rnd16());
    // Longest run; errors at both ends drive the clamp and the floor shift.
    queue_beat(FUNC_STRAIGHT, rnd16(), 16'hFFFF, rnd16());
    queue_beat(FUNC_TICK, 16'h0000, rnd16(), rnd16());
    queue_beat(FUNC_TICK, 16'h0001, rnd16(), rnd16());
    queue_beat(FUNC_TICK, 16'hFFFF, rnd16(), rnd16());
    // Turn that replaces the run; zero error with zero tolerance keeps
    // turning at the negative rate.
    queue_beat(FUNC_TURN, rnd16(), rnd16(), 16'h7FFF);
    queue_beat(FUNC_TICK, 16'hFFFF, rnd16(), rnd16());
    queue_beat(FUNC_TICK, 16'h0000, rnd16(), rnd16());
    queue_beat(FUNC_TICK, 16'hFFFD, rnd16(), rnd16());
    // Back-to-back commands, each replacing the one before.
    queue_beat(FUNC_TURN, rnd16(), rnd16(), 16'h8000);
    queue_beat(FUNC_TURN, rnd16(), rnd16(), 16'h0001);
    queue_beat(FUNC_STRAIGHT, rnd16(), 16'h0001, rnd16());
    queue_beat(FUNC_TICK, 16'h8000, rnd16(), rnd16());
    queue_beat(FUNC_TICK, 16'h8000, rnd16(), rnd16());
    queue_beat(FUNC_UNUSED, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(FUNC_TICK, 16'h0000, rnd16(), rnd16());
    queue_mission_mix(PHASE_ITEMS);
    wait_drained();

    // Phase two: lower extremes and the widest tolerance; sender idles more.
    write_all_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd32767, 32'd0);
    set_idling(86, 11);
    queue_mission_mix(PHASE_ITEMS);
    wait_drained();

    // Phase three: random settings at full rate, with one long hold-off on
    // the result side while the sender keeps offering beats.
    write_all_settings($urandom_range(0, 65535), $urandom_range(0, 32767),
                       $urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom_range(0, 4000), $urandom_range(1, 1023));
    set_idling(0, 0);
    base = accepted_beats;
    queue_mission_mix(PHASE_ITEMS);
    while (accepted_beats < base + 50) @(posedge clk);
    hold_kick <= 1'b1;
    wait_drained();

    // Phase four: back to the reset values; the turn ends exactly when the
    // error drops below the tolerance.
    write_all_settings(32'(RST_STEER_GAIN), 32'(RST_STEER_LIMIT), 32'(RST_DRIVE_SPEED),
                       32'(RST_TURN_RATE), 32'(RST_HEADING_TOL), 32'(RST_STEP_DISTANCE));
    @(negedge clk);
    queue_beat(FUNC_TURN, rnd16(), rnd16(), 16'h0000);
    queue_beat(FUNC_TICK, yaw_for_error(int'(RST_HEADING_TOL)), rnd16(), rnd16());
    queue_beat(FUNC_TICK, yaw_for_error(int'(RST_HEADING_TOL) - 1), rnd16(), rnd16());
    queue_mission_mix(PHASE_ITEMS);
    wait_drained();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/hdc_pkg.sv
hw/rtl/hdc_cfg_regs.sv
hw/rtl/hdc_core.sv
hw/rtl/heading_hold_drive_controller_top.sv
hw/rtl/hdc_checker.sv
tb/heading_hold_drive_controller_top_tb.sv
